// ----- rtl/sha1md_pkg.sv -----
// Shared types and constants for the SHA-1 message digest block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sha1md_pkg;

    // Input transaction: one optional message byte plus end flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    // Output transaction: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Command passed from the front end to the hash engine
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } cmd_t;

    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

// ----- rtl/sha1_message_digest.sv -----
// SHA-1 message digest top level: front end, command queue, hash engine.
// Depends on sha1md_pkg, sha1md_front, sha1md_queue, sha1md_engine.
`timescale 1ns / 1ps

// Streams message bytes in, one optional byte per transaction, and returns the
// 160-bit SHA-1 digest as five 32-bit words (H0 first) after the transaction
// that carries end_of_message. The engine takes in one byte at a time while
// idle; every 64th byte starts a compression (80 rounds on one shared round
// unit plus one chaining update) during which no bytes are taken. At the end
// of a message the engine pads out the block, runs one or two compressions,
// hands out the digest words and re-arms. A queue of QUEUE_DEPTH commands
// sits in front of the engine, so the source keeps going while a compression
// is under way until the queue fills, and input is still taken while a digest
// word waits in the output register.
module sha1_message_digest #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  sha1md_pkg::in_item_t  item,
    output logic                  digest_valid,
    input  logic                  digest_stall,
    output sha1md_pkg::out_item_t digest
);
    import sha1md_pkg::*;

    logic queue_full;
    logic push;
    logic pop;
    logic head_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    sha1md_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    sha1md_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    sha1md_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .pop          (pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

endmodule

// ----- rtl/sha1md_front.sv -----
// Front end: accepts input transactions and turns the useful ones into
// engine commands. Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_front (
    input  logic                 item_valid,
    output logic                 item_stall,
    input  sha1md_pkg::in_item_t item,
    input  logic                 queue_full,
    output logic                 push,
    output sha1md_pkg::cmd_t     cmd
);
    import sha1md_pkg::*;

    // Hold off the source while the command queue has no room
    assign item_stall = queue_full;

    // Items that carry neither a byte nor the end flag are dropped here
    assign push = item_valid && !queue_full && (item.byte_present || item.end_of_message);

    always_comb
    begin
        cmd.data    = item.data_byte;
        cmd.present = item.byte_present;
        cmd.last    = item.end_of_message;
    end

endmodule

// ----- rtl/sha1md_queue.sv -----
// Small command FIFO between the front end and the hash engine.
// Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sha1md_pkg::cmd_t push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output sha1md_pkg::cmd_t head_cmd
);
    import sha1md_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/sha1md_engine.sv -----
// Hash engine: block assembly, padding, 80-round compression and digest
// output register. Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  sha1md_pkg::cmd_t      cmd,
    output logic                  pop,
    output logic                  digest_valid,
    input  logic                  digest_stall,
    output sha1md_pkg::out_item_t digest
);
    import sha1md_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_PAD  = 2'd1;
    localparam logic [1:0] RET_OUT  = 2'd2;

    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd56;
    localparam logic [6:0] RND_LAST  = 7'(ROUNDS - 1);
    localparam logic [6:0] RND_K1    = 7'd20;
    localparam logic [6:0] RND_K2    = 7'd40;
    localparam logic [6:0] RND_K3    = 7'd60;
    localparam logic [2:0] IDX_LAST  = 3'(DIGEST_WORDS - 1);
    localparam logic [2:0] IDX_DONE  = 3'(DIGEST_WORDS);

    // Control state
    logic [2:0]  state_reg, state_next;
    logic [1:0]  ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] count_reg, count_next;
    logic        pad_first_reg, pad_first_next;
    logic        final_blk_reg, final_blk_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic        ov_reg, ov_next;
    logic [31:0] h_reg [DIGEST_WORDS];
    logic [31:0] h_next [DIGEST_WORDS];

    // Datapath
    logic [511:0] blk_reg, blk_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    out_item_t    ow_reg, ow_next;

    logic        shift_en;
    logic [7:0]  shift_byte;
    logic        start_round;
    logic [63:0] len_bits;
    logic [63:0] len_shift;
    logic [31:0] f_val, k_val, w_now, w_new, t_sum;
    logic        out_take, can_load;

    assign digest_valid = ov_reg;
    assign digest       = ow_reg;

    // Length field bytes, most significant first at positions 56..63
    assign len_bits  = {count_reg[60:0], 3'b000};
    assign len_shift = len_bits >> {~fill_reg[2:0], 3'b000};

    // Round function and schedule taps
    assign w_now = blk_reg[511 -: 32];
    assign w_new = {w_now ^ blk_reg[447 -: 32] ^ blk_reg[255 -: 32] ^ blk_reg[95 -: 32]}
                   << 1 | {31'd0, (w_now[31] ^ blk_reg[447] ^ blk_reg[255] ^ blk_reg[95])};

    always_comb
    begin
        priority if (round_reg < RND_K1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end
        else if (round_reg < RND_K2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end
        else if (round_reg < RND_K3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
    end

    assign t_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_now;

    assign out_take = ov_reg && !digest_stall;
    assign can_load = !ov_reg || out_take;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        pad_first_next = pad_first_reg;
        final_blk_next = final_blk_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        ov_next        = out_take ? 1'b0 : ov_reg;
        ow_next        = ow_reg;
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            h_next[i] = h_reg[i];
        end
        pop         = 1'b0;
        shift_en    = 1'b0;
        shift_byte  = cmd.data;
        start_round = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop = 1'b1;
                    if (cmd.present)
                    begin
                        shift_en   = 1'b1;
                        count_next = count_reg + 64'd1;
                        fill_next  = fill_reg + 6'd1;
                    end
                    if (cmd.present && fill_reg == FILL_LAST)
                    begin
                        start_round    = 1'b1;
                        state_next     = S_ROUND;
                        ret_next       = cmd.last ? RET_PAD : RET_IDLE;
                        pad_first_next = 1'b1;
                    end
                    else if (cmd.last)
                    begin
                        state_next     = S_PAD;
                        pad_first_next = 1'b1;
                    end
                end
            end

            S_PAD:
            begin
                shift_en  = 1'b1;
                fill_next = fill_reg + 6'd1;
                if (pad_first_reg)
                begin
                    shift_byte     = PAD_MARK;
                    pad_first_next = 1'b0;
                    final_blk_next = (fill_reg < FILL_LEN);
                end
                else if (fill_reg >= FILL_LEN && final_blk_reg)
                begin
                    shift_byte = len_shift[7:0];
                end
                else
                begin
                    shift_byte = 8'd0;
                end
                if (fill_reg == FILL_LAST)
                begin
                    start_round = 1'b1;
                    state_next  = S_ROUND;
                    ret_next    = (!pad_first_reg && final_blk_reg) ? RET_OUT : RET_PAD;
                end
            end

            S_ROUND:
            begin
                round_next = round_reg + 7'd1;
                if (round_reg == RND_LAST)
                begin
                    state_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                unique case (ret_reg)
                    RET_PAD:
                    begin
                        state_next     = S_PAD;
                        final_blk_next = 1'b1;
                    end
                    RET_OUT:
                    begin
                        state_next = S_OUT;
                        idx_next   = '0;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_OUT:
            begin
                if (idx_reg == IDX_DONE)
                begin
                    // Digest handed off; re-arm for the next message
                    h_next[0]  = H0_INIT;
                    h_next[1]  = H1_INIT;
                    h_next[2]  = H2_INIT;
                    h_next[3]  = H3_INIT;
                    h_next[4]  = H4_INIT;
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else if (can_load)
                begin
                    ov_next             = 1'b1;
                    ow_next.digest_word = h_reg[idx_reg];
                    ow_next.word_index  = idx_reg;
                    ow_next.last_word   = (idx_reg == IDX_LAST);
                    idx_next            = idx_reg + 3'd1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (start_round)
        begin
            round_next = '0;
        end
    end

    // Block register and working variables
    always_comb
    begin
        blk_next = blk_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        e_next   = e_reg;
        if (shift_en)
        begin
            blk_next = {blk_reg[503:0], shift_byte};
        end
        else if (state_reg == S_ROUND)
        begin
            blk_next = {blk_reg[479:0], w_new};
            a_next   = t_sum;
            b_next   = a_reg;
            c_next   = {b_reg[1:0], b_reg[31:2]};
            d_next   = c_reg;
            e_next   = d_reg;
        end
        if (start_round)
        begin
            a_next = h_reg[0];
            b_next = h_reg[1];
            c_next = h_reg[2];
            d_next = h_reg[3];
            e_next = h_reg[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= RET_IDLE;
            fill_reg      <= '0;
            count_reg     <= '0;
            pad_first_reg <= 1'b0;
            final_blk_reg <= 1'b0;
            round_reg     <= '0;
            idx_reg       <= '0;
            ov_reg        <= 1'b0;
            h_reg[0]      <= H0_INIT;
            h_reg[1]      <= H1_INIT;
            h_reg[2]      <= H2_INIT;
            h_reg[3]      <= H3_INIT;
            h_reg[4]      <= H4_INIT;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            pad_first_reg <= pad_first_next;
            final_blk_reg <= final_blk_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            ov_reg        <= ov_next;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        ow_reg  <= ow_next;
    end

endmodule

// ----- rtl/sha1md_checker.sv -----
// Port-level checks for sha1_message_digest and the bind that attaches them.
// Depends on sha1md_pkg and the top level's port list.
`timescale 1ns / 1ps

module sha1md_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_stall,
    input sha1md_pkg::in_item_t  item,
    input logic                  digest_valid,
    input logic                  digest_stall,
    input sha1md_pkg::out_item_t digest
);
    import sha1md_pkg::*;

    localparam logic [2:0] IDX_LAST = 3'(DIGEST_WORDS - 1);

    // A stalled input transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("input transaction changed while stalled");

    // A stalled digest word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid && $stable(digest))
        else $error("digest word changed while stalled");

    // Index stays within the digest
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> digest.word_index <= IDX_LAST)
        else $error("digest word index out of range");

    // Last flag marks exactly the final word
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_word == (digest.word_index == IDX_LAST)))
        else $error("last_word does not match word index");

    // Words of one digest come out in order
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall && !digest.last_word |=>
            !digest_valid || digest.word_index == $past(digest.word_index) + 3'd1)
        else $error("digest words out of order");

endmodule

bind sha1_message_digest sha1md_checker u_checker (.*);
